### rtl/uartrb_pkg.sv
// Package for the UART register block: request and result types, receive FIFO
// geometry, event and register codes, and the trigger level lookup.
// No dependencies.
`default_nettype none

package uartrb_pkg;

    localparam int RX_FIFO_DEPTH = 16;
    localparam int RX_IDX_W      = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int RX_CNT_W      = $clog2(RX_FIFO_DEPTH + 1);
    localparam int RX_SUM_W      = $clog2(2 * RX_FIFO_DEPTH);
    localparam int RX_ENTRY_W    = 11;

    localparam logic [2:0] KIND_READ    = 3'd0;
    localparam logic [2:0] KIND_WRITE   = 3'd1;
    localparam logic [2:0] KIND_RX_CHAR = 3'd2;
    localparam logic [2:0] KIND_TX_TAKE = 3'd3;
    localparam logic [2:0] KIND_MODEM   = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT = 3'd5;

    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    localparam logic [3:0] IID_NONE    = 4'h1;
    localparam logic [3:0] IID_LINE    = 4'h6;
    localparam logic [3:0] IID_RX_DATA = 4'h4;
    localparam logic [3:0] IID_TIMEOUT = 4'hC;
    localparam logic [3:0] IID_THRE    = 4'h2;
    localparam logic [3:0] IID_MODEM   = 4'h0;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
        logic       parity_err;
        logic       frame_err;
        logic       break_seen;
        logic       cts_line;
        logic       dsr_line;
        logic       ring_line;
        logic       dcd_line;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq;
        logic        tx_start;
        logic [7:0]  tx_data;
        logic [15:0] divisor;
        logic [6:0]  line_format;
        logic [4:0]  modem_ctl;
    } t_res;

    // Write side of the receive store.
    typedef struct packed {
        logic                  we;
        logic [RX_IDX_W-1:0]   addr;
        logic [RX_ENTRY_W-1:0] entry;
    } t_rx_wr;

    // Receive trigger level for a two-bit code, capped at the FIFO depth.
    function automatic logic [RX_CNT_W-1:0] trig_level(input logic [1:0] code);
        int lvl;
        begin
            case (code)
                2'd0:    lvl = 1;
                2'd1:    lvl = 4;
                2'd2:    lvl = 8;
                default: lvl = 14;
            endcase
            if (lvl > RX_FIFO_DEPTH) lvl = RX_FIFO_DEPTH;
            trig_level = RX_CNT_W'(lvl);
        end
    endfunction

endpackage

`default_nettype wire

### rtl/uartrb_rx_store.sv
// Receive FIFO storage of the UART register block: character and flag entries
// plus one error bit per entry. Uses uartrb_pkg.
`default_nettype none

module uartrb_rx_store (
    input  wire logic                               i_clk,
    input  wire uartrb_pkg::t_rx_wr                 i_wr,
    input  wire logic [uartrb_pkg::RX_IDX_W-1:0]    i_byte_addr,
    input  wire logic [uartrb_pkg::RX_IDX_W-1:0]    i_flag_addr,
    output logic [7:0]                              o_byte,
    output logic [2:0]                              o_flags,
    output logic [uartrb_pkg::RX_FIFO_DEPTH-1:0]    o_err
);
    import uartrb_pkg::*;

    logic [7:0]               r_bytes [RX_FIFO_DEPTH];
    logic [2:0]               r_flags [RX_FIFO_DEPTH];
    logic [RX_FIFO_DEPTH-1:0] r_err;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_bytes[i_wr.addr] <= i_wr.entry[7:0];
            r_flags[i_wr.addr] <= i_wr.entry[10:8];
            r_err[i_wr.addr]   <= |i_wr.entry[10:8];
        end
    end

    assign o_byte  = r_bytes[i_byte_addr];
    assign o_flags = r_flags[i_flag_addr];
    assign o_err   = r_err;

endmodule

`default_nettype wire

### rtl/uart_register_block.sv
// Top level of the UART register block: 16550-style register file with a
// receive FIFO and prioritised interrupt identification. Uses uartrb_pkg and
// uartrb_rx_store.
`default_nettype none

// Channel   Ports                  Handshake
// request   i_start, i_req         taken when i_start is high and o_busy is low
// result    o_done, o_res          one-cycle strobe, cannot be held off
//
// Every request is handled in the cycle it is taken and its result appears on
// the next cycle, so one request per clock is sustained; o_busy stays low.
// Synchronous active-low reset clears all register state but the result
// register; the receive store contents are not cleared, entries outside the
// FIFO occupancy are ignored.
// The receiver cannot stall, so no result is ever held back.

module uart_register_block (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire uartrb_pkg::t_req i_req,
    output logic                  o_busy,
    output logic                  o_done,
    output uartrb_pkg::t_res      o_res
);
    import uartrb_pkg::*;

    // Register state.
    logic [RX_CNT_W-1:0] r_count, n_count;
    logic [RX_IDX_W-1:0] r_head, n_head;
    logic [3:0]          r_ier, n_ier;
    logic [7:0]          r_lcr, n_lcr;
    logic [4:0]          r_mcr, n_mcr;
    logic [15:0]         r_dll, n_dll;
    logic [7:0]          r_scr, n_scr;
    logic [2:0]          r_fcr, n_fcr;
    logic                r_thr_full, n_thr_full;
    logic [7:0]          r_thr, n_thr;
    logic [3:0]          r_lsf, n_lsf;
    logic [7:0]          r_msr, n_msr;
    logic                r_thre, n_thre;
    logic                r_to, n_to;
    logic                r_done;
    t_res                r_res, n_res;

    logic [7:0]               head_byte;
    logic [2:0]               next_flags;
    logic [RX_FIFO_DEPTH-1:0] err_bits;
    logic [RX_IDX_W-1:0]      head_inc;
    logic [RX_IDX_W-1:0]      tail;
    logic [RX_SUM_W-1:0]      tail_sum;
    logic                     held_err;
    t_rx_wr                   wr;
    logic                     accept;

    assign accept = i_start && !o_busy;

    uartrb_rx_store u_rx_store (
        .i_clk       (i_clk),
        .i_wr        (wr),
        .i_byte_addr (r_head),
        .i_flag_addr (head_inc),
        .o_byte      (head_byte),
        .o_flags     (next_flags),
        .o_err       (err_bits)
    );

    // Interrupt identification over a given state, FIFO-enabled bits included.
    function automatic logic [7:0] int_id(
        input logic [2:0]          fcr,
        input logic [3:0]          ier,
        input logic [3:0]          lsf,
        input logic [RX_CNT_W-1:0] cnt,
        input logic                to,
        input logic                thre,
        input logic [7:0]          msr
    );
        logic [3:0]          code;
        logic [RX_CNT_W-1:0] need;
        begin
            need = fcr[0] ? trig_level(fcr[2:1]) : RX_CNT_W'(1);
            if (ier[2] && (lsf != 4'd0))                      code = IID_LINE;
            else if (ier[0] && (cnt != '0) && (cnt >= need))  code = IID_RX_DATA;
            else if (ier[0] && to)                            code = IID_TIMEOUT;
            else if (ier[1] && thre)                          code = IID_THRE;
            else if (ier[3] && (msr[3:0] != 4'd0))            code = IID_MODEM;
            else                                              code = IID_NONE;
            int_id = {fcr[0] ? 2'b11 : 2'b00, 2'b00, code};
        end
    endfunction

    // Pointer arithmetic around the receive ring.
    always_comb begin
        head_inc = (r_head == RX_IDX_W'(RX_FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
        tail_sum = RX_SUM_W'(r_head) + RX_SUM_W'(r_count);
        if (tail_sum >= RX_SUM_W'(RX_FIFO_DEPTH)) begin
            tail = RX_IDX_W'(tail_sum - RX_SUM_W'(RX_FIFO_DEPTH));
        end else begin
            tail = RX_IDX_W'(tail_sum);
        end
    end

    // Any occupied entry carrying an error flag, for line status bit 7.
    always_comb begin
        logic [RX_SUM_W-1:0] span;
        held_err = 1'b0;
        for (int k = 0; k < RX_FIFO_DEPTH; k++) begin
            if (RX_SUM_W'(k) >= RX_SUM_W'(r_head)) begin
                span = RX_SUM_W'(k) - RX_SUM_W'(r_head);
            end else begin
                span = RX_SUM_W'(k) + RX_SUM_W'(RX_FIFO_DEPTH) - RX_SUM_W'(r_head);
            end
            if (err_bits[k] && (span < RX_SUM_W'(r_count))) held_err = 1'b1;
        end
    end

    // One request is applied in full, in the order the device defines.
    always_comb begin
        logic                  dlab;
        logic                  fifo_on;
        logic [7:0]            wd;
        logic [7:0]            rd;
        logic [7:0]            iid;
        logic [7:0]            iid_next;
        logic [RX_ENTRY_W-1:0] entry;
        logic                  full;
        logic [3:0]            old_nib;
        logic [3:0]            new_nib;
        logic [3:0]            delta;

        n_count    = r_count;
        n_head     = r_head;
        n_ier      = r_ier;
        n_lcr      = r_lcr;
        n_mcr      = r_mcr;
        n_dll      = r_dll;
        n_scr      = r_scr;
        n_fcr      = r_fcr;
        n_thr_full = r_thr_full;
        n_thr      = r_thr;
        n_lsf      = r_lsf;
        n_msr      = r_msr;
        n_thre     = r_thre;
        n_to       = r_to;
        wr         = '0;
        rd         = 8'd0;
        delta      = 4'd0;
        n_res      = '0;

        dlab    = r_lcr[7];
        fifo_on = r_fcr[0];
        wd      = i_req.write_data;
        iid     = int_id(r_fcr, r_ier, r_lsf, r_count, r_to, r_thre, r_msr);
        entry   = {i_req.break_seen, i_req.frame_err, i_req.parity_err,
                   i_req.break_seen ? 8'd0 : i_req.rx_byte};
        full    = fifo_on ? (r_count >= RX_CNT_W'(RX_FIFO_DEPTH))
                          : (r_count >= RX_CNT_W'(1));
        old_nib = r_msr[7:4];
        new_nib = {i_req.dcd_line, i_req.ring_line, i_req.dsr_line, i_req.cts_line};

        case (i_req.kind)
            KIND_READ: begin
                case (i_req.reg_offset)
                    REG_DATA: begin
                        if (dlab) begin
                            rd = r_dll[7:0];
                        end else if (r_count != '0) begin
                            rd      = head_byte;
                            n_head  = head_inc;
                            n_count = r_count - 1'b1;
                            n_to    = 1'b0;
                            if (n_count != '0) n_lsf = n_lsf | {next_flags, 1'b0};
                        end
                    end
                    REG_IER: rd = dlab ? r_dll[15:8] : {4'd0, r_ier};
                    REG_IIR: begin
                        rd = iid;
                        if (iid[3:0] == IID_THRE) n_thre = 1'b0;
                    end
                    REG_LCR: rd = r_lcr;
                    REG_MCR: rd = {3'd0, r_mcr};
                    REG_LSR: begin
                        rd = {fifo_on && held_err, !r_thr_full, !r_thr_full,
                              r_lsf, r_count != '0};
                        n_lsf = 4'd0;
                    end
                    REG_MSR: begin
                        rd         = r_msr;
                        n_msr[3:0] = 4'd0;
                    end
                    default: rd = r_scr;
                endcase
            end
            KIND_WRITE: begin
                case (i_req.reg_offset)
                    REG_DATA: begin
                        if (dlab) begin
                            n_dll[7:0] = wd;
                        end else begin
                            n_thr      = wd;
                            n_thr_full = 1'b1;
                            n_thre     = 1'b0;
                        end
                    end
                    REG_IER: begin
                        if (dlab) begin
                            n_dll[15:8] = wd;
                        end else begin
                            n_ier = wd[3:0];
                            if (!r_ier[1] && wd[1] && !r_thr_full) n_thre = 1'b1;
                        end
                    end
                    REG_IIR: begin
                        // Switching the FIFO mode clears both sides; clear
                        // bits act only while the FIFO is being enabled.
                        if ((wd[0] && !fifo_on) || (!wd[0] && fifo_on)
                                || (wd[0] && wd[1])) begin
                            n_count = '0;
                            n_head  = '0;
                            n_to    = 1'b0;
                        end
                        if (((wd[0] && !fifo_on) || (!wd[0] && fifo_on)
                                || (wd[0] && wd[2])) && r_thr_full) begin
                            n_thr_full = 1'b0;
                            n_thr      = 8'd0;
                            n_thre     = 1'b1;
                        end
                        if (wd[0]) begin
                            n_fcr = {wd[7:6], 1'b1};
                        end else begin
                            n_fcr[0] = 1'b0;
                        end
                    end
                    REG_LCR: n_lcr = wd;
                    REG_MCR: n_mcr = wd[4:0];
                    REG_SCR: n_scr = wd;
                    default: ;
                endcase
            end
            KIND_RX_CHAR: begin
                wr.entry = entry;
                if (full) begin
                    n_lsf[0] = 1'b1;
                    if (!fifo_on) begin
                        // Without the FIFO the new character replaces the held one.
                        wr.we   = 1'b1;
                        wr.addr = r_head;
                        n_lsf   = n_lsf | {entry[10:8], 1'b0};
                    end
                end else begin
                    wr.we   = 1'b1;
                    wr.addr = tail;
                    n_count = r_count + 1'b1;
                    if (r_count == '0) n_lsf = n_lsf | {entry[10:8], 1'b0};
                end
            end
            KIND_TX_TAKE: begin
                if (r_thr_full) begin
                    n_res.tx_start = 1'b1;
                    n_res.tx_data  = r_thr;
                    n_thr_full     = 1'b0;
                    n_thr          = 8'd0;
                    n_thre         = 1'b1;
                end
            end
            KIND_MODEM: begin
                delta = {old_nib[3] ^ new_nib[3], old_nib[2] && !new_nib[2],
                         old_nib[1] ^ new_nib[1], old_nib[0] ^ new_nib[0]};
                n_msr = {new_nib, r_msr[3:0] | delta};
            end
            KIND_TIMEOUT: begin
                if (fifo_on && (r_count != '0)) n_to = 1'b1;
            end
            default: ;
        endcase

        iid_next          = int_id(n_fcr, n_ier, n_lsf, n_count, n_to, n_thre, n_msr);
        n_res.read_data   = rd;
        n_res.irq         = !iid_next[0] && n_mcr[3];
        n_res.divisor     = n_dll;
        n_res.line_format = n_lcr[6:0];
        n_res.modem_ctl   = n_mcr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_head     <= '0;
            r_ier      <= '0;
            r_lcr      <= '0;
            r_mcr      <= '0;
            r_dll      <= '0;
            r_scr      <= '0;
            r_fcr      <= '0;
            r_thr_full <= 1'b0;
            r_thr      <= '0;
            r_lsf      <= '0;
            r_msr      <= '0;
            r_thre     <= 1'b0;
            r_to       <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count    <= n_count;
                r_head     <= n_head;
                r_ier      <= n_ier;
                r_lcr      <= n_lcr;
                r_mcr      <= n_mcr;
                r_dll      <= n_dll;
                r_scr      <= n_scr;
                r_fcr      <= n_fcr;
                r_thr_full <= n_thr_full;
                r_thr      <= n_thr;
                r_lsf      <= n_lsf;
                r_msr      <= n_msr;
                r_thre     <= n_thre;
                r_to       <= n_to;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

### tb/tb_uart_register_block_checker.sv
// Checker for the UART register block: watches the request and result channels,
// predicts each result from its own copy of the register state and compares.
// Depends on uartrb_pkg.
`timescale 1ns / 100ps

module tb_uart_register_block_checker
    import uartrb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    input  wire logic i_busy,
    input  wire logic i_done,
    input  wire t_res i_res,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results
);

    logic [10:0] m_fifo [RX_FIFO_DEPTH];
    int          m_count;
    int          m_head;
    logic [3:0]  m_ier;
    logic [7:0]  m_lcr;
    logic [4:0]  m_mcr;
    logic [15:0] m_div;
    logic [7:0]  m_scr;
    logic [2:0]  m_fcr;
    logic [8:0]  m_thr;
    logic [3:0]  m_lsr_flags;
    logic [7:0]  m_msr;
    logic        m_thre_pend;
    logic        m_tout_pend;

    t_res expected_results [$];
    int   mismatches;

    function automatic bit fifo_is_on();
        return m_fcr[0];
    endfunction

    function automatic int rx_trigger();
        int lvl;
        case (m_fcr[2:1])
            2'd0:    lvl = 1;
            2'd1:    lvl = 4;
            2'd2:    lvl = 8;
            default: lvl = 14;
        endcase
        if (lvl > RX_FIFO_DEPTH) lvl = RX_FIFO_DEPTH;
        return lvl;
    endfunction

    // Error flags of the head entry latch into the line status.
    function automatic void latch_head_flags();
        if (m_count > 0) m_lsr_flags = m_lsr_flags | {m_fifo[m_head][10:8], 1'b0};
    endfunction

    function automatic void clear_receive();
        m_count = 0;
        m_head = 0;
        m_tout_pend = 1'b0;
    endfunction

    function automatic void clear_transmit();
        if (m_thr[8]) begin
            m_thr = '0;
            m_thre_pend = 1'b1;
        end
    endfunction

    function automatic logic [7:0] irq_ident();
        logic [3:0] code;
        int need;
        code = IID_NONE;
        need = fifo_is_on() ? rx_trigger() : 1;
        if (m_ier[2] && m_lsr_flags != 0) code = IID_LINE;
        else if (m_ier[0] && m_count > 0 && m_count >= need) code = IID_RX_DATA;
        else if (m_ier[0] && m_tout_pend) code = IID_TIMEOUT;
        else if (m_ier[1] && m_thre_pend) code = IID_THRE;
        else if (m_ier[3] && m_msr[3:0] != 0) code = IID_MODEM;
        return {fifo_is_on() ? 2'b11 : 2'b00, 2'b00, code};
    endfunction

    function automatic logic [7:0] line_status();
        logic [7:0] v;
        v = {3'b000, m_lsr_flags, 1'b0};
        if (m_count > 0) v[0] = 1'b1;
        if (!m_thr[8]) v[6:5] = 2'b11;
        if (fifo_is_on())
            for (int k = 0; k < m_count; k++)
                if (m_fifo[(m_head + k) % RX_FIFO_DEPTH][10:8] != 0) v[7] = 1'b1;
        return v;
    endfunction

    function automatic void predict_reset();
        clear_receive();
        m_ier = '0; m_lcr = '0; m_mcr = '0; m_div = '0; m_scr = '0;
        m_fcr = '0; m_thr = '0; m_lsr_flags = '0; m_msr = '0;
        m_thre_pend = 1'b0;
    endfunction

    function automatic void register_read(input logic [2:0] off, output logic [7:0] v);
        v = '0;
        case (off)
            REG_DATA: begin
                if (m_lcr[7]) v = m_div[7:0];
                else if (m_count > 0) begin
                    v = m_fifo[m_head][7:0];
                    m_head = (m_head + 1) % RX_FIFO_DEPTH;
                    m_count--;
                    m_tout_pend = 1'b0;
                    latch_head_flags();
                end
            end
            REG_IER: v = m_lcr[7] ? m_div[15:8] : {4'b0, m_ier};
            REG_IIR: begin
                v = irq_ident();
                if (v[3:0] == IID_THRE) m_thre_pend = 1'b0;
            end
            REG_LCR: v = m_lcr;
            REG_MCR: v = {3'b0, m_mcr};
            REG_LSR: begin
                v = line_status();
                m_lsr_flags = '0;
            end
            REG_MSR: begin
                v = m_msr;
                m_msr[3:0] = '0;
            end
            default: v = m_scr;
        endcase
    endfunction

    function automatic void register_write(input logic [2:0] off, input logic [7:0] v);
        case (off)
            REG_DATA: begin
                if (m_lcr[7]) m_div[7:0] = v;
                else begin
                    m_thr = {1'b1, v};
                    m_thre_pend = 1'b0;
                end
            end
            REG_IER: begin
                if (m_lcr[7]) m_div[15:8] = v;
                else begin
                    if (!m_ier[1] && v[1] && !m_thr[8]) m_thre_pend = 1'b1;
                    m_ier = v[3:0];
                end
            end
            REG_IIR: begin
                if (v[0]) begin
                    if (!fifo_is_on()) begin
                        clear_receive();
                        clear_transmit();
                    end
                    m_fcr = {v[7:6], 1'b1};
                    if (v[1]) clear_receive();
                    if (v[2]) clear_transmit();
                end else begin
                    if (fifo_is_on()) begin
                        clear_receive();
                        clear_transmit();
                    end
                    m_fcr[0] = 1'b0;
                end
            end
            REG_LCR: m_lcr = v;
            REG_MCR: m_mcr = v[4:0];
            REG_SCR: m_scr = v;
            default: ;
        endcase
    endfunction

    function automatic void receive_char(input t_req r);
        logic [10:0] e;
        int cap;
        e = {r.break_seen, r.frame_err, r.parity_err, r.break_seen ? 8'h00 : r.rx_byte};
        cap = fifo_is_on() ? RX_FIFO_DEPTH : 1;
        if (m_count >= cap) begin
            m_lsr_flags[0] = 1'b1;
            if (!fifo_is_on()) begin
                m_fifo[m_head] = e;
                latch_head_flags();
            end
        end else begin
            m_fifo[(m_head + m_count) % RX_FIFO_DEPTH] = e;
            m_count++;
            if (m_count == 1) latch_head_flags();
        end
    endfunction

    function automatic void modem_change(input t_req r);
        logic [3:0] now_lines, old_lines, delta;
        now_lines = {r.dcd_line, r.ring_line, r.dsr_line, r.cts_line};
        old_lines = m_msr[7:4];
        delta = {old_lines[3] ^ now_lines[3], old_lines[2] & ~now_lines[2],
                 old_lines[1] ^ now_lines[1], old_lines[0] ^ now_lines[0]};
        m_msr = {now_lines, m_msr[3:0] | delta};
    endfunction

    function automatic t_res predict_request(input t_req r);
        t_res x;
        logic [7:0] iid;
        x = '0;
        case (r.kind)
            KIND_READ:    register_read(r.reg_offset, x.read_data);
            KIND_WRITE:   register_write(r.reg_offset, r.write_data);
            KIND_RX_CHAR: receive_char(r);
            KIND_TX_TAKE: begin
                if (m_thr[8]) begin
                    x.tx_start = 1'b1;
                    x.tx_data = m_thr[7:0];
                    m_thr = '0;
                    m_thre_pend = 1'b1;
                end
            end
            KIND_MODEM:   modem_change(r);
            KIND_TIMEOUT: if (fifo_is_on() && m_count > 0) m_tout_pend = 1'b1;
            default: ;
        endcase
        iid = irq_ident();
        x.irq = !iid[0] && m_mcr[3];
        x.divisor = m_div;
        x.line_format = m_lcr[6:0];
        x.modem_ctl = m_mcr;
        return x;
    endfunction

    // The result is sampled in the same always block before the new request
    // is predicted, so ordering within the step never matters.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            predict_reset();
            expected_results.delete();
        end else begin
            if (i_done) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (mismatches < 10) $display("unexpected result %p", i_res);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_res) begin
                        o_fail_count <= o_fail_count + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p, got %p", want, i_res);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) expected_results.push_back(predict_request(i_req));
        end
        o_pending <= expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_results = 0;
        mismatches = 0;
    end

endmodule

### tb/tb_uart_register_block.sv
// Testbench top for the UART register block: drives directed requests back to back
// and random requests with random gaps, and reports the verdict from the checker's count.
// Depends on uartrb_pkg, uart_register_block and tb_uart_register_block_checker.
`timescale 1ns / 100ps

module tb_uart_register_block;
    import uartrb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_res o_res;
    int   fail_count;
    int   pending;
    int   results;
    int   cycles;
    int   requests_sent;

    uart_register_block dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    tb_uart_register_block_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_req        (i_req),
        .i_busy       (o_busy),
        .i_done       (o_done),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog ends a run that has hung.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_uart_register_block NOT OK");
            $finish;
        end
    end

    // Sends one request. start stays high across back-to-back requests, and it
    // is only lowered when a gap follows, so no signal is assigned twice in a step.
    task automatic send_request(input t_req r, input bit allow_gap);
        int gap;
        i_start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        requests_sent++;
        gap = 0;
        if (allow_gap) begin
            // Now and then a short gap, more rarely a long one, and mostly none.
            if ($urandom_range(0, 99) < 8) gap = $urandom_range(10, 40);
            else if ($urandom_range(0, 99) < 40) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_req random_fields();
        t_req r;
        logic [31:0] raw;
        raw = $urandom();
        r = raw[$bits(t_req)-1:0];
        return r;
    endfunction

    function automatic t_req make_req(input logic [2:0] kind, input logic [2:0] off,
                                      input logic [7:0] data);
        t_req r;
        r = random_fields();
        r.kind = kind;
        r.reg_offset = off;
        r.write_data = data;
        return r;
    endfunction

    function automatic t_req rx_char(input logic [7:0] b, input bit pe, input bit fe,
                                     input bit brk);
        t_req r;
        r = make_req(KIND_RX_CHAR, REG_DATA, 8'h00);
        r.rx_byte = b;
        r.parity_err = pe;
        r.frame_err = fe;
        r.break_seen = brk;
        return r;
    endfunction

    // Random request, weighted towards receive traffic and register reads so
    // that the FIFO fills, overruns and drains under every interrupt setting.
    function automatic t_req random_request();
        t_req r;
        int pick;
        r = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 30) r.kind = KIND_READ;
        else if (pick < 50) r.kind = KIND_WRITE;
        else if (pick < 75) r.kind = KIND_RX_CHAR;
        else if (pick < 83) r.kind = KIND_TX_TAKE;
        else if (pick < 91) r.kind = KIND_MODEM;
        else if (pick < 98) r.kind = KIND_TIMEOUT;
        else r.kind = 3'($urandom_range(6, 7));
        // Error flags are rarer than clean characters.
        if (r.kind == KIND_RX_CHAR && $urandom_range(0, 3) != 0) begin
            r.parity_err = 1'b0;
            r.frame_err = 1'b0;
            r.break_seen = 1'b0;
        end
        // Keep the divisor latch selected only now and then.
        if (r.kind == KIND_WRITE && r.reg_offset == REG_LCR && $urandom_range(0, 2) != 0)
            r.write_data[7] = 1'b0;
        return r;
    endfunction

    initial begin
        cycles = 0;
        requests_sent = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty receive read, divisor latch at both extremes,
        // overrun with the FIFO off, break character, FIFO on with the top
        // trigger, timeout, transmit take, modem deltas and the ignored writes.
        send_request(make_req(KIND_READ, REG_DATA, 8'h00), 1'b0);
        send_request(make_req(KIND_WRITE, REG_LCR, 8'hFF), 1'b0);
        send_request(make_req(KIND_WRITE, REG_DATA, 8'hFF), 1'b0);
        send_request(make_req(KIND_WRITE, REG_IER, 8'hFF), 1'b0);
        send_request(make_req(KIND_READ, REG_IER, 8'h00), 1'b0);
        send_request(make_req(KIND_WRITE, REG_LCR, 8'h03), 1'b0);
        send_request(make_req(KIND_WRITE, REG_MCR, 8'hFF), 1'b0);
        send_request(make_req(KIND_WRITE, REG_IER, 8'h0F), 1'b0);
        send_request(rx_char(8'hFF, 1'b0, 1'b0, 1'b0), 1'b0);
        send_request(rx_char(8'h5A, 1'b1, 1'b1, 1'b0), 1'b0);
        send_request(rx_char(8'hA5, 1'b0, 1'b0, 1'b1), 1'b0);
        send_request(make_req(KIND_READ, REG_IIR, 8'h00), 1'b0);
        send_request(make_req(KIND_READ, REG_LSR, 8'h00), 1'b0);
        send_request(make_req(KIND_READ, REG_DATA, 8'h00), 1'b0);
        send_request(make_req(KIND_WRITE, REG_IIR, 8'hC7), 1'b0);
        for (int k = 0; k < 17; k++) send_request(rx_char(8'(k * 15), 1'b0, 1'b0, 1'b0), 1'b0);
        send_request(make_req(KIND_TIMEOUT, REG_DATA, 8'h00), 1'b0);
        send_request(make_req(KIND_WRITE, REG_DATA, 8'h81), 1'b0);
        send_request(make_req(KIND_TX_TAKE, REG_DATA, 8'h00), 1'b0);
        send_request(make_req(KIND_MODEM, REG_DATA, 8'h00) | t_req'(7'h7F), 1'b0);
        send_request(make_req(KIND_MODEM, REG_DATA, 8'h00) & ~t_req'(7'h7F), 1'b0);
        send_request(make_req(KIND_READ, REG_MSR, 8'h00), 1'b0);
        send_request(make_req(KIND_WRITE, REG_LSR, 8'hFF), 1'b0);
        send_request(make_req(KIND_WRITE, REG_MSR, 8'hFF), 1'b0);
        send_request(make_req(KIND_WRITE, REG_SCR, 8'h00), 1'b0);

        // Random part.
        for (int n = 0; n < 600; n++) send_request(random_request(), 1'b1);
        i_start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results across all register and",
                 requests_sent, results);
        $display("line event kinds, with the receive FIFO both on and off.");
        if (fail_count == 0) begin
            $display("tb_uart_register_block OK");
        end else begin
            $display("tb_uart_register_block NOT OK");
        end
        $finish;
    end

endmodule
